/* hdl/olst_pkg.sv */
`default_nettype none

package olst_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int POS_W      = 5;
  localparam int CNT_W      = 5;
  localparam int FUNC_W     = 3;
  localparam int OP_W       = 3;

  // Request codes as they arrive on the input channel.
  localparam logic [FUNC_W-1:0] FUNC_APPEND       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE_LAST  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INSERT       = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE_VALUE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE_AT    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_READ         = 3'd5;

  // Internal operation classes handed from the front end to the back end.
  localparam logic [OP_W-1:0] OP_BAD          = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND       = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_LAST  = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT       = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_READ         = 3'd6;

  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic signed [DATA_WIDTH-1:0] value;
    logic [POS_W-1:0]             position;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] read_value;
    logic [CNT_W-1:0]             count;
    logic                         found;
    logic                         error;
  } res_t;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [DATA_WIDTH-1:0] value;
    logic [POS_W-1:0]      position;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/ordered_list_engine.sv */
`default_nettype none

// Ordered list engine: an ordered list of up to 16 signed 32-bit words.
// Requests enter through a queue-style port: drive req and raise push; the
// item is taken at a clock edge where push is high and full is low.
// Each request yields exactly one result item, read queue-style: while empty
// is low the oldest result sits on res, and pop at an edge takes it.
// The front end classifies the request code and holds up to two requests;
// the back end keeps the list cells and carries out one request at a time.
// Throughput is one item per cycle while the result queue has room; remove
// value holds the back end for a compare step over every cell and then a
// shift step over the list.
// A two-entry result queue lets the back end keep working while the receiver
// holds off pop; when it fills, the back end stops and the request queue
// raises full. Synchronous reset empties the list and both queues; cell
// contents are not cleared and are never read before they are written.

module ordered_list_engine
  import olst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire req_t req,
  output logic      empty,
  input  wire logic pop,
  output res_t      res
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  olst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  olst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

endmodule

`default_nettype wire

/* hdl/olst_front.sv */
`default_nettype none

module olst_front
  import olst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire req_t req,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic cmd_take
);

  cmd_t       fq_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fq_count;
  logic       fq_push;
  logic       fq_pop;
  cmd_t       cmd_in;

  // Classify the request code; unused codes become a failing operation.
  always_comb begin
    cmd_in.value    = req.value;
    cmd_in.position = req.position;
    case (req.func)
      FUNC_APPEND:       cmd_in.op = OP_APPEND;
      FUNC_REMOVE_LAST:  cmd_in.op = OP_REMOVE_LAST;
      FUNC_INSERT:       cmd_in.op = OP_INSERT;
      FUNC_REMOVE_VALUE: cmd_in.op = OP_REMOVE_VALUE;
      FUNC_REMOVE_AT:    cmd_in.op = OP_REMOVE_AT;
      FUNC_READ:         cmd_in.op = OP_READ;
      default:           cmd_in.op = OP_BAD;
    endcase
  end

  assign full      = (fq_count == 2'd2);
  assign cmd_valid = (fq_count != 2'd0);
  assign cmd       = fq_mem[rd_ptr];
  assign fq_push   = push && !full;
  assign fq_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (fq_push) begin
      fq_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fq_count <= 2'd0;
    end else begin
      if (fq_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (fq_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fq_count <= fq_count + {1'b0, fq_push} - {1'b0, fq_pop};
    end
  end

endmodule

`default_nettype wire

/* hdl/olst_back.sv */
`default_nettype none

module olst_back
  import olst_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_take,
  output logic      empty,
  input  wire logic pop,
  output res_t      res
);

  logic [DATA_WIDTH-1:0] cells      [DEPTH];
  logic [DATA_WIDTH-1:0] cells_next [DEPTH];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  searching;
  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      match_next;

  res_t                  rq_mem [2];
  logic                  rq_wr_ptr;
  logic                  rq_rd_ptr;
  logic [1:0]            rq_count;
  logic                  rq_pop;
  logic                  space;
  logic                  done;
  res_t                  res_next;

  logic                  ins_en;
  logic [CNT_W-1:0]      ins_pos;
  logic                  del_en;
  logic [CNT_W-1:0]      del_pos;
  logic                  hit;
  logic [CNT_W-1:0]      hit_pos;

  assign rq_pop   = pop && !empty;
  assign space    = (rq_count != 2'd2) || rq_pop;
  assign cmd_take = cmd_valid && !searching && space;
  assign done     = (cmd_take && (cmd.op != OP_REMOVE_VALUE)) || searching;

  // Lowest matching cell wins.
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_pos = CNT_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_next[i] = (CNT_W'(i) < count) && (cells[i] == cmd.value);
    end
  end

  always_comb begin
    ins_en              = 1'b0;
    ins_pos             = count;
    del_en              = 1'b0;
    del_pos             = cmd.position;
    count_next          = count;
    res_next.read_value = '0;
    res_next.found      = 1'b0;
    res_next.error      = 1'b0;
    if (searching) begin
      if (hit) begin
        del_en         = 1'b1;
        del_pos        = hit_pos;
        count_next     = count - 1'b1;
        res_next.found = 1'b1;
      end
    end else if (cmd_take) begin
      case (cmd.op)
        OP_APPEND: begin
          if (count < CNT_W'(DEPTH)) begin
            ins_en     = 1'b1;
            count_next = count + 1'b1;
          end else begin
            res_next.error = 1'b1;
          end
        end
        OP_INSERT: begin
          if ((count < CNT_W'(DEPTH)) && (cmd.position <= count)) begin
            ins_en     = 1'b1;
            ins_pos    = cmd.position;
            count_next = count + 1'b1;
          end else begin
            res_next.error = 1'b1;
          end
        end
        OP_REMOVE_LAST: begin
          if (count != '0) begin
            count_next = count - 1'b1;
          end else begin
            res_next.error = 1'b1;
          end
        end
        OP_REMOVE_AT: begin
          if (cmd.position < count) begin
            del_en     = 1'b1;
            count_next = count - 1'b1;
          end else begin
            res_next.error = 1'b1;
          end
        end
        OP_READ: begin
          if (cmd.position < count) begin
            res_next.read_value = cells[cmd.position[$clog2(DEPTH)-1:0]];
          end else begin
            res_next.error = 1'b1;
          end
        end
        OP_REMOVE_VALUE: begin
          // Compare this cycle, shift and answer in the next one.
        end
        default: begin
          res_next.error = 1'b1;
        end
      endcase
    end
    res_next.count = count_next;
  end

  // Cells past the count may take stale values; they are never read.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_next[i] = cells[i];
      if (ins_en) begin
        if (CNT_W'(i) == ins_pos) begin
          cells_next[i] = cmd.value;
        end else if ((i > 0) && (CNT_W'(i) > ins_pos)) begin
          cells_next[i] = cells[(i > 0) ? i - 1 : 0];
        end
      end else if (del_en) begin
        if ((i < DEPTH - 1) && (CNT_W'(i) >= del_pos)) begin
          cells_next[i] = cells[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
    if (cmd_take) begin
      match <= match_next;
    end
    if (done) begin
      rq_mem[rq_wr_ptr] <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      searching <= 1'b0;
      rq_wr_ptr <= 1'b0;
      rq_rd_ptr <= 1'b0;
      rq_count  <= 2'd0;
    end else begin
      count     <= count_next;
      searching <= cmd_take && (cmd.op == OP_REMOVE_VALUE);
      if (done) begin
        rq_wr_ptr <= !rq_wr_ptr;
      end
      if (rq_pop) begin
        rq_rd_ptr <= !rq_rd_ptr;
      end
      rq_count <= rq_count + {1'b0, done} - {1'b0, rq_pop};
    end
  end

  assign empty = (rq_count == 2'd0);
  assign res   = rq_mem[rq_rd_ptr];

`ifndef NO_ASSERTIONS
  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    done |-> ((rq_count != 2'd2) || rq_pop))
    else $error("result queue written while full");

  a_search_one_cycle: assert property (@(posedge clk) disable iff (rst)
    searching |=> !searching)
    else $error("value search lasted more than one cycle");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (done && res_next.error) |=> (count == $past(count)))
    else $error("failed request changed the count");

  a_found_shrinks: assert property (@(posedge clk) disable iff (rst)
    (done && res_next.found) |=> (count == $past(count) - 1'b1))
    else $error("matched removal did not shrink the list");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(DEPTH)) |-> !ins_en)
    else $error("insert into a full list");
`endif

endmodule

`default_nettype wire

/* verif/tb_ordered_list_engine.sv */
module tb_ordered_list_engine;
  import olst_pkg::*;

  // The request field has room for two codes that the block must reject.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int RANDOM_ITEMS    = 1760;
  localparam int BIAS_SPAN       = 48;

  class list_shadow;
    logic signed [DATA_WIDTH-1:0] cells [DEPTH];
    int fill;
    res_t expected_results [$];
    int mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function void note_request(req_t r);
      res_t e;
      int i;
      int hit;
      e = '0;
      hit = -1;
      case (r.func)
        FUNC_APPEND: begin
          if (fill >= DEPTH) begin
            e.error = 1'b1;
          end else begin
            cells[fill] = r.value;
            fill++;
          end
        end
        FUNC_REMOVE_LAST: begin
          if (fill == 0) e.error = 1'b1;
          else fill--;
        end
        FUNC_INSERT: begin
          if (fill >= DEPTH || int'(r.position) > fill) begin
            e.error = 1'b1;
          end else begin
            for (i = fill; i > int'(r.position); i--) cells[i] = cells[i-1];
            cells[r.position] = r.value;
            fill++;
          end
        end
        FUNC_REMOVE_VALUE: begin
          for (i = 0; i < fill; i++) begin
            if (hit < 0 && cells[i] == r.value) hit = i;
          end
          if (hit >= 0) begin
            for (i = hit; i < fill - 1; i++) cells[i] = cells[i+1];
            fill--;
            e.found = 1'b1;
          end
        end
        FUNC_REMOVE_AT: begin
          if (int'(r.position) >= fill) begin
            e.error = 1'b1;
          end else begin
            for (i = int'(r.position); i < fill - 1; i++) cells[i] = cells[i+1];
            fill--;
          end
        end
        FUNC_READ: begin
          if (int'(r.position) >= fill) e.error = 1'b1;
          else e.read_value = cells[r.position];
        end
        default: e.error = 1'b1;
      endcase
      e.count = CNT_W'(fill);
      expected_results.insert(expected_results.size(), e);
    endfunction

    function void report(string field, logic signed [DATA_WIDTH-1:0] want,
                         logic signed [DATA_WIDTH-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.read_value !== want.read_value)
        report("read_value", want.read_value, got.read_value);
      if (got.count !== want.count) report("count", want.count, got.count);
      if (got.found !== want.found) report("found", want.found, got.found);
      if (got.error !== want.error) report("error", want.error, got.error);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  req_t req = '0;
  logic full;
  logic empty;
  res_t res;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  list_shadow shadow;

  ordered_list_engine dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .req   (req),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: checks each popped item and decides the next pop.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) shadow.check_result(res);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("ordered_list_engine verification failed");
    $finish;
  end

  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    shadow.note_request(r);
  endtask

  task automatic send(logic [FUNC_W-1:0] f, logic signed [DATA_WIDTH-1:0] v, int p);
    req_t r;
    r.func = f;
    r.value = v;
    r.position = POS_W'(p);
    send_request(r);
  endtask

  // Growing stretches drive the list to full; shrinking ones drain it to empty.
  function automatic req_t random_request(bit grow);
    req_t r;
    int pick;
    int pct;
    int t_app, t_ins, t_rml, t_rmv, t_rma, t_rd;
    if (grow) begin
      t_app = 35; t_ins = 65; t_rml = 71; t_rmv = 80; t_rma = 86; t_rd = 97;
    end else begin
      t_app = 6; t_ins = 12; t_rml = 36; t_rmv = 58; t_rma = 82; t_rd = 97;
    end
    pick = $urandom_range(99);
    if (pick < t_app) r.func = FUNC_APPEND;
    else if (pick < t_ins) r.func = FUNC_INSERT;
    else if (pick < t_rml) r.func = FUNC_REMOVE_LAST;
    else if (pick < t_rmv) r.func = FUNC_REMOVE_VALUE;
    else if (pick < t_rma) r.func = FUNC_REMOVE_AT;
    else if (pick < t_rd) r.func = FUNC_READ;
    else r.func = $urandom_range(1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;

    // Values already in the list and small values make matches and duplicates likely.
    pct = $urandom_range(99);
    if (pct < 40 && shadow.fill > 0) r.value = shadow.cells[$urandom_range(shadow.fill - 1)];
    else if (pct < 65) r.value = int'($urandom_range(6)) - 3;
    else if (pct < 75) r.value = pct[0] ? 32'sh7fffffff : 32'sh80000000;
    else r.value = $urandom;

    if ($urandom_range(99) < 85) r.position = POS_W'($urandom_range(shadow.fill));
    else r.position = POS_W'($urandom_range(31));
    return r;
  endfunction

  initial begin : stimulus
    int phase;
    int n;
    shadow = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Every operation but append on an empty list.
    send(FUNC_READ, 0, 0);
    send(FUNC_REMOVE_LAST, 0, 0);
    send(FUNC_REMOVE_VALUE, 0, 0);
    send(FUNC_REMOVE_AT, 0, 0);
    send(FUNC_INSERT, 9, 1);
    // Build a short list with the extreme values and a duplicate.
    send(FUNC_INSERT, 32'sh7fffffff, 0);
    send(FUNC_APPEND, 32'sh80000000, 0);
    send(FUNC_APPEND, -1, 0);
    send(FUNC_APPEND, 0, 0);
    send(FUNC_INSERT, 5, 4);
    send(FUNC_INSERT, 0, 2);
    send(FUNC_READ, 0, 0);
    send(FUNC_READ, 0, 5);
    send(FUNC_READ, 0, 6);
    send(FUNC_READ, 0, 31);
    // Only the first of the two zeros goes.
    send(FUNC_REMOVE_VALUE, 0, 0);
    send(FUNC_REMOVE_VALUE, 123, 0);
    send(FUNC_REMOVE_AT, 0, 0);
    send(FUNC_REMOVE_AT, 0, 31);
    send(FUNC_INSERT, -7, 31);
    send(FUNC_UNUSED_LO, 1, 0);
    send(FUNC_UNUSED_HI, 1, 0);
    send(FUNC_REMOVE_LAST, 0, 0);
    send(FUNC_READ, 0, 2);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
        // A long pop hold-off while items keep coming backs the block up to full.
        if (phase == 0 && n == 100) hold_request = 1'b1;
        send_request(random_request((n / BIAS_SPAN) % 2 == 0));
      end
    end
    push <= 1'b0;

    while (shadow.expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.expected_results.size() == 0) begin
      $display("ordered_list_engine verification clean");
    end else begin
      $display("ordered_list_engine verification failed");
    end
    $finish;
  end

endmodule
